[rtl/vdr_pkg.sv]
// Shared types and codes for the vertex dedup reindexer.
`default_nettype none
package vdr_pkg;

  localparam int unsigned IDX_W    = 32;
  localparam int unsigned COORD_W  = 24;
  localparam int unsigned VERT_W   = 2 * COORD_W;
  localparam int unsigned THR_W    = 51;
  localparam int unsigned UCNT_W   = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 51;

  localparam logic [IDX_W-1:0] RESTART_MARKER_RST = '1;
  localparam logic [THR_W-1:0] MATCH_DIST_RST = THR_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESTART_MARKER = 1'b0,
    CFG_MATCH_DIST     = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OUT_MATCHED = 2'd0,
    OUT_STORED  = 2'd1,
    OUT_RESTART = 2'd2,
    OUT_FULL    = 2'd3
  } outcome_e;

  // status from the distance unit back to the sequencer
  typedef struct packed {
    logic hit;
    logic busy;
  } match_stat_t;

endpackage
`default_nettype wire

[rtl/vertex_dedup_reindexer.sv]
// Top level: rewrites an index stream into a table of unique 2D vertices.
// Each non-restart item walks the whole ring of MAX_VERTICES vertex slots,
// one slot per cycle past a three-stage distance unit at the ring head. The
// result is registered once the walk is over and the last live compare has
// drained from the distance unit; a stalled result beat holds it back. The
// next item is taken only after the result lands in the output register. A
// restart item skips the walk and goes straight to the finish state. The walk
// always covers every slot: the ring must come back to its home position
// before the next item. Slots hold no reset value; only slots below the
// vertex count are ever compared, and a beat with first_of_list set empties
// the table before it is handled.
`default_nettype none
module vertex_dedup_reindexer #(
  parameter int unsigned MAX_VERTICES = 256
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // config write channel
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [vdr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [vdr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input items
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [vdr_pkg::IDX_W-1:0]       source_index_i,
  input  wire  signed [vdr_pkg::COORD_W-1:0] pos_x_i,
  input  wire  signed [vdr_pkg::COORD_W-1:0] pos_y_i,
  input  wire                             first_of_list_i,
  input  wire                             last_of_list_i,
  // results
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [vdr_pkg::IDX_W-1:0]       new_index_o,
  output vdr_pkg::outcome_e               outcome_o,
  output logic [vdr_pkg::UCNT_W-1:0]      unique_count_o,
  output logic                            list_done_o
);
  import vdr_pkg::*;

  localparam int unsigned IW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  // config registers
  logic [IDX_W-1:0] marker_q;
  logic [THR_W-1:0] thr_q;

  // current item
  logic [IDX_W-1:0]   idx_q;
  logic [COORD_W-1:0] qx_q, qy_q;
  logic               last_q, restart_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] sc_q, sc_d;
  logic          found_q, found_d;
  logic [IW-1:0] fidx_q, fidx_d;

  logic             ovalid_q, ovalid_d;
  logic [IDX_W-1:0] onew_q, onew_d;
  outcome_e         oout_q, oout_d;
  logic [CW-1:0]    ocnt_q, ocnt_d;
  logic             olast_q;

  logic in_acc, issuing, shift, store_en, fin_go, out_free;
  logic [VERT_W-1:0] ring [MAX_VERTICES];
  match_stat_t       mstat;
  logic [IW-1:0]     mtag;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= RESTART_MARKER_RST;
      thr_q    <= MATCH_DIST_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_RESTART_MARKER: marker_q <= cfg_data_i[IDX_W-1:0];
        CFG_MATCH_DIST:     thr_q    <= cfg_data_i[THR_W-1:0];
        default:            ;
      endcase
    end
  end

  // ---------------- vertex ring ----------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign issuing    = (state_q == ST_SCAN) && (sc_q != MAX_CNT);
  assign shift      = issuing;
  assign out_free   = !ovalid_q || out_ready_i;
  assign fin_go     = (state_q == ST_FINISH) && out_free;
  assign store_en   = fin_go && !restart_q && !found_q && (cnt_q != MAX_CNT);

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
    localparam int unsigned NEXT = (k + 1) % MAX_VERTICES;
    vdr_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (shift),
      .load_i      (store_en && (cnt_q[IW-1:0] == IW'(k))),
      .shift_in_i  (ring[NEXT]),
      .load_data_i ({qy_q, qx_q}),
      .vert_o      (ring[k])
    );
  end

  vdr_match #(
    .TAG_W (IW)
  ) u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (issuing && (sc_q < cnt_q)),
    .tag_i   (sc_q[IW-1:0]),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .vert_i  (ring[0]),
    .thr_i   (thr_q),
    .stat_o  (mstat),
    .tag_o   (mtag)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    sc_d     = sc_q;
    found_d  = found_q;
    fidx_d   = fidx_q;
    ovalid_d = ovalid_q && !out_ready_i;
    onew_d   = onew_q;
    oout_d   = oout_q;
    ocnt_d   = ocnt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sc_d    = '0;
          found_d = 1'b0;
          if (first_of_list_i) begin
            cnt_d = '0;
          end
          state_d = (source_index_i == marker_q) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issuing) begin
          sc_d = sc_q + CW'(1);
        end else if (!mstat.busy) begin
          state_d = ST_FINISH;
        end
        // hits arrive in slot order, so the first one wins
        if (mstat.hit && !found_q) begin
          found_d = 1'b1;
          fidx_d  = mtag;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ocnt_d   = cnt_q;
          if (restart_q) begin
            onew_d = idx_q;
            oout_d = OUT_RESTART;
          end else if (found_q) begin
            onew_d = IDX_W'(fidx_q);
            oout_d = OUT_MATCHED;
          end else if (cnt_q != MAX_CNT) begin
            onew_d = IDX_W'(cnt_q);
            oout_d = OUT_STORED;
            cnt_d  = cnt_q + CW'(1);
            ocnt_d = cnt_q + CW'(1);
          end else begin
            onew_d = '0;
            oout_d = OUT_FULL;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      sc_q     <= '0;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sc_q     <= sc_d;
      found_q  <= found_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fidx_q <= fidx_d;
    onew_q <= onew_d;
    oout_q <= oout_d;
    ocnt_q <= ocnt_d;
    if (in_acc) begin
      idx_q     <= source_index_i;
      qx_q      <= pos_x_i;
      qy_q      <= pos_y_i;
      last_q    <= last_of_list_i;
      restart_q <= (source_index_i == marker_q);
    end
    if (fin_go) begin
      olast_q <= last_q;
    end
  end

  logic [CW+UCNT_W-1:0] ocnt_ext;
  assign ocnt_ext = {{UCNT_W{1'b0}}, ocnt_q};

  assign out_valid_o    = ovalid_q;
  assign new_index_o    = onew_q;
  assign outcome_o      = oout_q;
  assign unique_count_o = ocnt_ext[UCNT_W-1:0];
  assign list_done_o    = olast_q;

endmodule
`default_nettype wire

[rtl/vdr_cell.sv]
// One slot of the rotating vertex ring.
`default_nettype none
module vdr_cell (
  input  wire                          clk_i,
  input  wire                          shift_i,
  input  wire                          load_i,
  input  wire  [vdr_pkg::VERT_W-1:0]   shift_in_i,
  input  wire  [vdr_pkg::VERT_W-1:0]   load_data_i,
  output logic [vdr_pkg::VERT_W-1:0]   vert_o
);
  import vdr_pkg::*;

  logic [VERT_W-1:0] vert_q, vert_d;

  always_comb begin
    vert_d = vert_q;
    if (load_i) begin
      vert_d = load_data_i;
    end else if (shift_i) begin
      vert_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vert_q <= vert_d;
  end

  assign vert_o = vert_q;

endmodule
`default_nettype wire

[rtl/vdr_match.sv]
// Pipelined distance test between the query vertex and the ring head.
`default_nettype none
module vdr_match #(
  parameter int unsigned TAG_W = 8
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         valid_i,
  input  wire  [TAG_W-1:0]            tag_i,
  input  wire  [vdr_pkg::COORD_W-1:0] qx_i,
  input  wire  [vdr_pkg::COORD_W-1:0] qy_i,
  input  wire  [vdr_pkg::VERT_W-1:0]  vert_i,
  input  wire  [vdr_pkg::THR_W-1:0]   thr_i,
  output vdr_pkg::match_stat_t        stat_o,
  output logic [TAG_W-1:0]            tag_o
);
  import vdr_pkg::*;

  localparam int unsigned DW = COORD_W + 1;
  localparam int unsigned SW = 2 * DW;

  logic [COORD_W-1:0] sx, sy;
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0] ax_d, ay_d;

  // stage 1: absolute differences
  logic           v1_q, eq1_q;
  logic [TAG_W-1:0] tag1_q;
  logic [DW-1:0]  ax_q, ay_q;
  // stage 2: squares
  logic           v2_q, eq2_q;
  logic [TAG_W-1:0] tag2_q;
  logic [SW-1:0]  sqx_q, sqy_q;
  // stage 3: sum and compare
  logic           v3_q, eq3_q;
  logic [TAG_W-1:0] tag3_q;
  logic [SW-1:0]  sqx3_q, sqy3_q;
  logic [THR_W-1:0] dsq;

  assign sx = vert_i[COORD_W-1:0];
  assign sy = vert_i[VERT_W-1:COORD_W];
  assign dx = $signed({qx_i[COORD_W-1], qx_i}) - $signed({sx[COORD_W-1], sx});
  assign dy = $signed({qy_i[COORD_W-1], qy_i}) - $signed({sy[COORD_W-1], sy});
  assign ax_d = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay_d = dy[DW-1] ? DW'(-dy) : DW'(dy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    eq1_q  <= (sx == qx_i) && (sy == qy_i);
    tag1_q <= tag_i;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    eq2_q  <= eq1_q;
    tag2_q <= tag1_q;
    sqx_q  <= ax_q * ax_q;
    sqy_q  <= ay_q * ay_q;
    eq3_q  <= eq2_q;
    tag3_q <= tag2_q;
    sqx3_q <= sqx_q;
    sqy3_q <= sqy_q;
  end

  assign dsq = THR_W'(sqx3_q) + THR_W'(sqy3_q);

  // bit-identical positions match even with a zero threshold
  assign stat_o.hit  = v3_q && (eq3_q || (dsq < thr_i));
  assign stat_o.busy = v1_q || v2_q || v3_q;
  assign tag_o       = tag3_q;

endmodule
`default_nettype wire

[bench/vdr_checker.sv]
// Scoreboard for the vertex dedup reindexer: predicts each result beat and checks it in order.
`default_nettype none
module vdr_checker #(
  parameter int unsigned TBL_DEPTH = 256
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  input  wire                              cfg_ready_i,
  input  wire  [vdr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [vdr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire                              in_valid_i,
  input  wire                              in_ready_i,
  input  wire  [vdr_pkg::IDX_W-1:0]        source_index_i,
  input  wire  [vdr_pkg::COORD_W-1:0]      pos_x_i,
  input  wire  [vdr_pkg::COORD_W-1:0]      pos_y_i,
  input  wire                              first_of_list_i,
  input  wire                              last_of_list_i,
  input  wire                              out_valid_i,
  input  wire                              out_ready_i,
  input  wire  [vdr_pkg::IDX_W-1:0]        new_index_i,
  input  vdr_pkg::outcome_e                outcome_i,
  input  wire  [vdr_pkg::UCNT_W-1:0]       unique_count_i,
  input  wire                              list_done_i,
  output int unsigned                      errors_o,
  output int unsigned                      in_flight_o
);

  typedef struct packed {
    logic [vdr_pkg::IDX_W-1:0]  new_index;
    vdr_pkg::outcome_e          outcome;
    logic [vdr_pkg::UCNT_W-1:0] count;
    logic                       done;
  } reindex_t;

  logic [vdr_pkg::VERT_W-1:0] kept_vtx [TBL_DEPTH];
  int unsigned                kept_cnt;
  logic [vdr_pkg::IDX_W-1:0]  restart_idx;
  logic [vdr_pkg::THR_W-1:0]  near_limit;
  reindex_t                   reindex_q [$];
  int unsigned                mismatches = 0;
  int unsigned                in_flight;

  assign errors_o    = mismatches;
  assign in_flight_o = in_flight;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic close_enough(input logic [vdr_pkg::VERT_W-1:0] kept,
                                        input logic [vdr_pkg::COORD_W-1:0] x,
                                        input logic [vdr_pkg::COORD_W-1:0] y);
    longint dx;
    longint dy;
    longint dsq;
    if (kept == {y, x}) return 1'b1;
    dx  = longint'($signed(x)) - longint'($signed(kept[vdr_pkg::COORD_W-1:0]));
    dy  = longint'($signed(y)) - longint'($signed(kept[vdr_pkg::VERT_W-1:vdr_pkg::COORD_W]));
    dsq = dx * dx + dy * dy;
    return dsq < longint'({13'd0, near_limit});
  endfunction

  // Restart items keep their index; else walks the kept vertices from slot 0; first hit wins, else append or flag full.
  task automatic reindex(input logic [vdr_pkg::IDX_W-1:0] idx,
                         input logic [vdr_pkg::COORD_W-1:0] x,
                         input logic [vdr_pkg::COORD_W-1:0] y,
                         input logic first, input logic last, output reindex_t r);
    int unsigned j;
    logic        hit;
    r.new_index = '0;
    r.done      = last;
    hit         = 1'b0;
    if (first) kept_cnt = 0;
    if (idx == restart_idx) begin
      r.new_index = idx;
      r.outcome   = vdr_pkg::OUT_RESTART;
    end else begin
      for (j = 0; j < kept_cnt && !hit; j++) begin
        if (close_enough(kept_vtx[j], x, y)) begin
          hit         = 1'b1;
          r.new_index = j;
        end
      end
      if (hit) begin
        r.outcome = vdr_pkg::OUT_MATCHED;
      end else if (kept_cnt < TBL_DEPTH) begin
        kept_vtx[kept_cnt] = {y, x};
        r.new_index        = kept_cnt;
        r.outcome          = vdr_pkg::OUT_STORED;
        kept_cnt++;
      end else begin
        r.outcome = vdr_pkg::OUT_FULL;
      end
    end
    r.count = vdr_pkg::UCNT_W'(kept_cnt);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reindex_t    want;
    int unsigned pushed;
    int unsigned popped;
    if (!rst_ni) begin
      kept_cnt    = 0;
      restart_idx = vdr_pkg::RESTART_MARKER_RST;
      near_limit  = vdr_pkg::MATCH_DIST_RST;
      reindex_q.delete();
      in_flight  <= 0;
    end else begin
      pushed = 0;
      popped = 0;
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          vdr_pkg::CFG_RESTART_MARKER: restart_idx = cfg_data_i[vdr_pkg::IDX_W-1:0];
          vdr_pkg::CFG_MATCH_DIST:     near_limit  = cfg_data_i[vdr_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      // result side first: a beat leaving now belongs to an older item
      if (out_valid_i && out_ready_i) begin
        if (reindex_q.size() == 0) begin
          report("result beat with nothing pending, new_index", new_index_i, '0);
        end else begin
          want   = reindex_q.pop_front();
          popped = 1;
          if (new_index_i !== want.new_index)
            report("new_index", new_index_i, want.new_index);
          if (outcome_i !== want.outcome)
            report("outcome", outcome_i, want.outcome);
          if (unique_count_i !== want.count)
            report("unique_count", unique_count_i, want.count);
          if (list_done_i !== want.done)
            report("list_done", list_done_i, want.done);
        end
      end
      if (in_valid_i && in_ready_i) begin
        reindex(source_index_i, pos_x_i, pos_y_i, first_of_list_i, last_of_list_i, want);
        reindex_q.push_back(want);
        pushed = 1;
      end
      in_flight <= in_flight + pushed - popped;
    end
  end

endmodule
`default_nettype wire

[bench/testbench.sv]
// Stimulus and verdict for the vertex dedup reindexer, checked by vdr_checker.
`default_nettype none
module testbench;

  localparam int unsigned TBL_DEPTH    = 256;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS  = 280;
  localparam logic [vdr_pkg::THR_W-1:0] THR_MAX = '1;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [vdr_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [vdr_pkg::CFG_DATA_W-1:0]   cfg_data;
  logic                             in_valid;
  logic                             in_ready;
  logic [vdr_pkg::IDX_W-1:0]        src_idx;
  logic signed [vdr_pkg::COORD_W-1:0] pos_x;
  logic signed [vdr_pkg::COORD_W-1:0] pos_y;
  logic                             first_flag;
  logic                             last_flag;
  logic                             out_valid;
  logic                             out_ready;
  logic [vdr_pkg::IDX_W-1:0]        new_idx;
  vdr_pkg::outcome_e                outcome;
  logic [vdr_pkg::UCNT_W-1:0]       ucount;
  logic                             list_done;
  int unsigned                      errors;
  int unsigned                      in_flight;

  logic                      quiet;
  logic [vdr_pkg::IDX_W-1:0] marker_now;
  logic [vdr_pkg::VERT_W-1:0] recent_q [$];

  always #4 clk = ~clk;

  vertex_dedup_reindexer #(.MAX_VERTICES(TBL_DEPTH)) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .source_index_i (src_idx),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .first_of_list_i(first_flag),
    .last_of_list_i (last_flag),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .new_index_o    (new_idx),
    .outcome_o      (outcome),
    .unique_count_o (ucount),
    .list_done_o    (list_done)
  );

  vdr_checker #(.TBL_DEPTH(TBL_DEPTH)) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .source_index_i (src_idx),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .first_of_list_i(first_flag),
    .last_of_list_i (last_flag),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .new_index_i    (new_idx),
    .outcome_i      (outcome),
    .unique_count_i (ucount),
    .list_done_i    (list_done),
    .errors_o       (errors),
    .in_flight_o    (in_flight)
  );

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (quiet || roll < 4) return 0;
    if (roll == 9) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [vdr_pkg::COORD_W-1:0] corner();
    case ($urandom_range(0, 3))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  task automatic send(input logic [vdr_pkg::IDX_W-1:0] idx,
                      input logic [vdr_pkg::COORD_W-1:0] x,
                      input logic [vdr_pkg::COORD_W-1:0] y,
                      input logic first, input logic last);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    src_idx    <= idx;
    pos_x      <= x;
    pos_y      <= y;
    first_flag <= first;
    last_flag  <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every pending result beat has left
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  task automatic configure(input logic [vdr_pkg::IDX_W-1:0] marker,
                           input logic [vdr_pkg::THR_W-1:0] limit);
    marker_now = marker;
    cfg_valid <= 1'b1;
    cfg_index <= vdr_pkg::CFG_RESTART_MARKER;
    cfg_data  <= {19'($urandom), marker};   // upper bits are don't-care for this register
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= vdr_pkg::CFG_MATCH_DIST;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Lists of random length; bulk lists carry mostly fresh vertices to run the table full.
  task automatic run_phase(input int unsigned n_items, input logic bulk_first);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    int unsigned roll;
    logic        bulk;
    logic        first;
    logic        last;
    logic [vdr_pkg::IDX_W-1:0]   idx;
    logic [vdr_pkg::COORD_W-1:0] x;
    logic [vdr_pkg::COORD_W-1:0] y;
    sent = 0;
    while (sent < n_items) begin
      bulk = (sent == 0 && bulk_first) || ($urandom_range(0, 9) == 0);
      len  = bulk ? $urandom_range(290, 330) : $urandom_range(1, 40);
      if (len > n_items - sent) len = n_items - sent;
      quiet = ($urandom_range(0, 4) == 0);
      recent_q.delete();
      for (k = 0; k < len; k++) begin
        if (k == 0) first = bulk || ($urandom_range(0, 15) != 0);
        else        first = !bulk && ($urandom_range(0, 39) == 0);
        if (k == len - 1) last = ($urandom_range(0, 15) != 0);
        else              last = ($urandom_range(0, 39) == 0);
        idx = (!bulk && $urandom_range(0, 11) == 0) ? marker_now : $urandom;
        roll = $urandom_range(0, 9);
        if ((bulk && roll < 9) || (recent_q.size() == 0 && roll < 9)) roll = 0;
        if (roll < 4) begin
          x = 24'($urandom);
          y = 24'($urandom);
        end else if (roll < 9) begin
          {y, x} = recent_q[$urandom_range(0, recent_q.size() - 1)];
          if (roll >= 7) begin
            x = x + 24'($urandom_range(0, 8)) - 24'd4;
            y = y + 24'($urandom_range(0, 8)) - 24'd4;
          end
        end else begin
          x = corner();
          y = corner();
        end
        if (recent_q.size() < 32) recent_q.push_back({y, x});
        send(idx, x, y, first, last);
      end
      sent += len;
    end
    quiet = 1'b0;
  endtask

  // sink side: random back-pressure on the result channel
  initial begin : sink
    int unsigned hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no beat for %0d cycles at %0t", STALL_LIMIT, $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = vdr_pkg::CFG_RESTART_MARKER;
    cfg_data   = '0;
    in_valid   = 1'b0;
    src_idx    = '0;
    pos_x      = '0;
    pos_y      = '0;
    first_flag = 1'b0;
    last_flag  = 1'b0;
    quiet      = 1'b0;
    marker_now = vdr_pkg::RESTART_MARKER_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: identical positions only, all-ones marks a restart
    send(32'd0,        24'h000000, 24'h000000, 1'b1, 1'b0);
    send(32'd1,        24'h000000, 24'h000000, 1'b0, 1'b0);
    send(32'hFFFFFFFF, 24'h000000, 24'h000000, 1'b0, 1'b0);
    send(32'd2,        24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0);
    send(32'd3,        24'h800000, 24'h800000, 1'b0, 1'b0);
    send(32'd4,        24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
    send(32'd5,        24'h800000, 24'h7FFFFF, 1'b0, 1'b0);
    send(32'hFFFFFFFE, 24'h000001, 24'h000000, 1'b0, 1'b0);  // one LSB away: not a match
    send(32'd6,        24'h000001, 24'h000000, 1'b0, 1'b0);
    send(32'd7,        24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b1);
    send(32'hFFFFFFFF, 24'h000005, 24'h000005, 1'b1, 1'b1);  // restart still clears the table
    send(32'd8,        24'h000005, 24'h000005, 1'b0, 1'b0);
    settle();

    // zero threshold, restart marker zero
    configure(32'd0, '0);
    send(32'd0,  24'h000005, 24'h000005, 1'b0, 1'b0);
    send(32'd9,  24'h000005, 24'h000005, 1'b0, 1'b0);
    send(32'd10, 24'h000005, 24'h000006, 1'b0, 1'b0);
    send(32'd11, 24'h800000, 24'h7FFFFF, 1'b1, 1'b0);
    send(32'd12, 24'h7FFFFF, 24'h800000, 1'b0, 1'b1);
    settle();

    // widest threshold: opposite corners still match
    configure(32'hFFFFFFFF, THR_MAX);
    send(32'd13, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0);
    send(32'd14, 24'h800000, 24'h800000, 1'b0, 1'b1);
    settle();

    configure(32'hFFFFFFFF, 51'd1);
    run_phase(PHASE_ITEMS, 1'b0);
    settle();
    configure(32'd0, '0);
    run_phase(PHASE_ITEMS, 1'b1);
    settle();
    configure($urandom, THR_MAX);
    run_phase(PHASE_ITEMS, 1'b0);
    settle();
    configure($urandom, 51'($urandom_range(2, 64)));
    run_phase(PHASE_ITEMS, 1'b0);
    settle();
    configure($urandom, 51'($urandom_range(65, 2 ** 30)));
    run_phase(PHASE_ITEMS, 1'b1);
    settle();
    configure($urandom, {19'($urandom), 32'($urandom)});
    run_phase(PHASE_ITEMS, 1'b0);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
